/* src/ple_pkg.sv */
package ple_pkg;

    localparam int Depth      = 64;
    localparam int PosW       = 7;
    localparam int IdxW       = 6;
    localparam int WordW      = 32;
    localparam int FuncW      = 3;
    localparam int StatW      = 3;
    localparam int QueueDepth = 2;

    typedef enum logic [FuncW-1:0] {
        FN_SETLEN = 3'd0,
        FN_WRITE  = 3'd1,
        FN_READ   = 3'd2,
        FN_INSERT = 3'd3,
        FN_DELETE = 3'd4,
        FN_SEARCH = 3'd5,
        FN_NOP6   = 3'd6,
        FN_NOP7   = 3'd7
    } func_t;

    typedef enum logic [StatW-1:0] {
        ST_OK       = 3'd0,
        ST_BADPOS   = 3'd1,
        ST_FULL     = 3'd2,
        ST_EMPTY    = 3'd3,
        ST_NOTFOUND = 3'd4
    } status_t;

    typedef struct packed {
        func_t             func;
        logic [PosW-1:0]   position;
        logic [WordW-1:0]  value;
    } cmd_t;

    typedef struct packed {
        status_t           status;
        logic [WordW-1:0]  read_value;
        logic [PosW-1:0]   found_position;
        logic [PosW-1:0]   list_length;
    } rsp_t;

endpackage

/* src/ple_front.sv */
module ple_front
    import ple_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  cmd_t        in_cmd,
    output logic        q_valid,
    input  logic        q_ready,
    output cmd_t        q_cmd
);

    cmd_t       buf_reg [QueueDepth];
    logic [0:0] wp_reg, wp_next, rp_reg, rp_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       push, pop;

    assign in_ready = (cnt_reg != 2'(QueueDepth));
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_cmd    = buf_reg[rp_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;

    always_comb
    begin
        wp_next  = push ? wp_reg + 1'b1 : wp_reg;
        rp_next  = pop ? rp_reg + 1'b1 : rp_reg;
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            buf_reg[wp_reg] <= in_cmd;
        end
    end

endmodule

/* src/ple_back.sv */
module ple_back
    import ple_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  q_valid,
    output logic  q_ready,
    input  cmd_t  q_cmd,
    output logic  out_valid,
    input  logic  out_ready,
    output rsp_t  out_rsp
);

    logic [WordW-1:0] cell_reg [Depth];
    logic [PosW-1:0]  len_reg;
    logic             ov_reg;
    rsp_t             rsp_reg;
    cmd_t             c;
    logic             take;
    logic             pos_ok;
    logic [IdxW-1:0]  idx;
    logic [Depth-1:0] hit;
    logic [IdxW-1:0]  hit_idx;
    logic             hit_any;
    logic [PosW:0]    len_ext;
    rsp_t             r;
    logic [PosW-1:0]  len_new;

    assign c       = q_cmd;
    assign q_ready = !ov_reg || out_ready;
    assign take    = q_valid && q_ready;
    assign pos_ok  = (c.position != '0) && (c.position <= len_reg);
    assign idx     = IdxW'(c.position - 7'd1);
    assign len_ext = {1'b0, len_reg};

    always_comb
    begin
        for (int i = 0; i < Depth; i++)
        begin
            hit[i] = (cell_reg[i] == c.value) && (i < int'(len_reg));
        end
        hit_idx = '0;
        hit_any = 1'b0;
        for (int i = Depth - 1; i >= 0; i--)
        begin
            if (hit[i])
            begin
                hit_idx = IdxW'(i);
                hit_any = 1'b1;
            end
        end
    end

    always_comb
    begin
        r.status         = ST_OK;
        r.read_value     = '0;
        r.found_position = '0;
        len_new          = len_reg;
        unique case (c.func)
            FN_SETLEN:
                if (c.position > PosW'(Depth)) r.status = ST_BADPOS;
                else len_new = c.position;
            FN_WRITE:
                if (!pos_ok) r.status = ST_BADPOS;
            FN_READ:
                if (!pos_ok) r.status = ST_BADPOS;
                else r.read_value = cell_reg[idx];
            FN_INSERT:
                if (len_ext >= (PosW+1)'(Depth)) r.status = ST_FULL;
                else if (!pos_ok) r.status = ST_BADPOS;
                else len_new = len_reg + 7'd1;
            FN_DELETE:
                if (!pos_ok) r.status = ST_BADPOS;
                else len_new = len_reg - 7'd1;
            FN_SEARCH:
                if (len_reg == '0) r.status = ST_EMPTY;
                else if (!hit_any) r.status = ST_NOTFOUND;
                else r.found_position = {1'b0, hit_idx} + 7'd1;
            default: ;
        endcase
        r.list_length = len_new;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg <= '0;
            ov_reg  <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                len_reg <= len_new;
                ov_reg  <= 1'b1;
            end
            else if (out_ready)
            begin
                ov_reg <= 1'b0;
            end
        end
    end

    // cells above the list length keep their contents
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            rsp_reg <= r;
            for (int i = 0; i < Depth; i++)
            begin
                if (c.func == FN_WRITE && pos_ok && IdxW'(i) == idx)
                    cell_reg[i] <= c.value;
                else if (c.func == FN_INSERT && pos_ok && len_ext < (PosW+1)'(Depth))
                begin
                    if (IdxW'(i) == idx) cell_reg[i] <= c.value;
                    else if (i > 0 && IdxW'(i) > idx && i <= int'(len_reg))
                        cell_reg[i] <= cell_reg[(i+Depth-1)%Depth];
                end
                else if (c.func == FN_DELETE && pos_ok && IdxW'(i) >= idx
                         && i + 1 < int'(len_reg))
                    cell_reg[i] <= cell_reg[(i+1)%Depth];
            end
        end
    end

    assign out_valid = ov_reg;
    assign out_rsp   = rsp_reg;

endmodule

/* src/positional_list_engine.sv */
// channel | dir | tdata bits (low first)                                 | tuser
// s_axis  | in  | position[6:0] value[38:7] pad                          | func[2:0]
// m_axis  | out | read_value[31:0] found_position[38:32] list_length[45:39] | status[2:0]
// one transaction per cycle enters a two-entry queue while it has room; the back end
// takes one per cycle unless stalled and registers its result in its output register
// the back end stalls only when its output register is full and not taken
// rst_n clears the length, queue and output valid; list cells are undefined until written
module positional_list_engine
    import ple_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // position, value
    input  logic [2:0]  s_axis_tuser,   // func
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // read_value, found_position, list_length
    output logic [2:0]  m_axis_tuser    // status
);

    cmd_t in_cmd, q_cmd;
    logic q_valid, q_ready;
    rsp_t rsp;

    assign in_cmd.func     = func_t'(s_axis_tuser);
    assign in_cmd.position = s_axis_tdata[6:0];
    assign in_cmd.value    = s_axis_tdata[38:7];

    ple_front u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_cmd(in_cmd),
        .q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd)
    );

    ple_back u_back (
        .clk(clk), .rst_n(rst_n),
        .q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd),
        .out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_rsp(rsp)
    );

    assign m_axis_tdata = {2'b00, rsp.list_length, rsp.found_position, rsp.read_value};
    assign m_axis_tuser = rsp.status;

endmodule

/* src/ple_checker.sv */
module ple_assertions
    import ple_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [47:0] m_axis_tdata,
    input logic [2:0]  m_axis_tuser
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result dropped while stalled");

    a_len: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[45:39] <= 7'(Depth))
        else $error("length beyond depth");

    a_rd: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser != ST_OK |-> m_axis_tdata[31:0] == '0)
        else $error("read word on failed request");

    a_fnd: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[38:32] != '0 |->
            m_axis_tdata[38:32] <= m_axis_tdata[45:39])
        else $error("found position beyond length");

    a_nohold: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> $past(s_axis_tvalid) || $past(!s_axis_tready))
        else $error("ready dropped with no input");

endmodule

bind positional_list_engine ple_assertions u_ple_assertions (
    .clk(clk), .rst_n(rst_n),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
);

/* bench/ple_checker.sv */
`timescale 1ns / 100ps

module ple_checker
    import ple_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,
    input  logic [2:0]  s_axis_tuser,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [47:0] m_axis_tdata,
    input  logic [2:0]  m_axis_tuser,
    output int          errors,
    output int          pending
);

    logic [WordW-1:0] cells [Depth];
    logic [PosW-1:0]  cur_len;
    rsp_t             expected_rsps [$];

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    function automatic rsp_t apply_cmd(input func_t fn, input logic [PosW-1:0] pos,
                                       input logic [WordW-1:0] val);
        rsp_t r;
        logic pos_ok;
        int i;
        r = '0;
        r.status = ST_OK;
        pos_ok = (pos >= 1) && (pos <= cur_len);
        case (fn)
            FN_SETLEN: if (pos > Depth) r.status = ST_BADPOS; else cur_len = pos;
            FN_WRITE:  if (!pos_ok) r.status = ST_BADPOS; else cells[pos-1] = val;
            FN_READ:   if (!pos_ok) r.status = ST_BADPOS; else r.read_value = cells[pos-1];
            FN_INSERT:
                if (cur_len >= Depth) r.status = ST_FULL;
                else if (!pos_ok) r.status = ST_BADPOS;
                else
                begin
                    for (i = cur_len; i > pos - 1; i--) cells[i] = cells[i-1];
                    cells[pos-1] = val;
                    cur_len++;
                end
            FN_DELETE:
                if (!pos_ok) r.status = ST_BADPOS;
                else
                begin
                    for (i = pos - 1; i + 1 < cur_len; i++) cells[i] = cells[i+1];
                    cur_len--;
                end
            FN_SEARCH:
                if (cur_len == 0) r.status = ST_EMPTY;
                else
                begin
                    r.status = ST_NOTFOUND;
                    for (i = 0; i < cur_len; i++)
                        if (cells[i] === val)
                        begin
                            r.status = ST_OK;
                            r.found_position = PosW'(i + 1);
                            break;
                        end
                end
            default: ;
        endcase
        r.list_length = cur_len;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_len = '0;
            errors = 0;
            expected_rsps.delete();
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_rsps.size() == 0)
                    report("unexpected transaction", m_axis_tdata, 0);
                else
                begin
                    rsp_t w;
                    w = expected_rsps.pop_front();
                    if (m_axis_tuser !== w.status) report("status", m_axis_tuser, w.status);
                    if (m_axis_tdata[31:0] !== w.read_value)
                        report("read_value", m_axis_tdata[31:0], w.read_value);
                    if (m_axis_tdata[38:32] !== w.found_position)
                        report("found_position", m_axis_tdata[38:32], w.found_position);
                    if (m_axis_tdata[45:39] !== w.list_length)
                        report("list_length", m_axis_tdata[45:39], w.list_length);
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                expected_rsps.push_back(apply_cmd(func_t'(s_axis_tuser), s_axis_tdata[6:0],
                                                  s_axis_tdata[38:7]));
        end
    end

    assign pending = expected_rsps.size();

endmodule

/* bench/tb.sv */
`timescale 1ns / 100ps

module tb;
    import ple_pkg::*;

    logic        clk = 0;
    logic        rst_n = 0;
    logic        s_axis_tvalid = 0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata = '0;
    logic [2:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 0;
    logic [47:0] m_axis_tdata;
    logic [2:0]  m_axis_tuser;
    int          errors;
    int          pending;
    int          cycles = 0;
    int          hold_off = 0;
    int          len_model = 0;
    int          hw_model = 0;
    int          gap_left = 0;
    int          burst_left = 0;

    always
    begin
        #6 clk = 1;
        #6 clk = 0;
    end

    positional_list_engine dut (.*);

    ple_checker chk (.*);

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > 400000)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // receiver stall pattern, with a long hold-off when requested
    always @(negedge clk)
    begin
        if (hold_off > 0)
        begin
            hold_off--;
            m_axis_tready <= 0;
        end
        else if ((cycles / 200) % 3 == 0)
            m_axis_tready <= 1;
        else
            m_axis_tready <= ($urandom_range(0, 3) != 0);
    end

    task automatic send(input func_t fn, input int pos, input logic [31:0] val);
        if ((cycles / 300) % 4 != 0)
        begin
            if (burst_left == 0)
            begin
                gap_left = $urandom_range(0, 4);
                burst_left = $urandom_range(1, 12);
            end
            while (gap_left > 0)
            begin
                @(negedge clk);
                s_axis_tvalid <= 0;
                gap_left--;
            end
            burst_left--;
        end
        @(negedge clk);
        s_axis_tvalid <= 1;
        s_axis_tuser <= fn;
        s_axis_tdata <= {1'b0, val, 7'(pos)};
        do @(posedge clk); while (!s_axis_tready);
        // track length and the written span to keep reads and searches off unwritten cells
        case (fn)
            FN_SETLEN: if (pos <= Depth) len_model = pos;
            FN_INSERT:
                if (len_model < Depth && pos >= 1 && pos <= len_model)
                begin
                    len_model++;
                    if (len_model > hw_model) hw_model = len_model;
                end
            FN_DELETE: if (pos >= 1 && pos <= len_model) len_model--;
            default: ;
        endcase
    endtask

    task automatic idle_out();
        @(negedge clk);
        s_axis_tvalid <= 0;
        while (pending != 0) @(posedge clk);
        repeat (5) @(posedge clk);
    endtask

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'hffff_ffff;
            3: return 32'd0;
            default: return $urandom();
        endcase
    endfunction

    function automatic int rand_pos();
        case ($urandom_range(0, 9))
            0: return 0;
            1: return len_model + 1;
            2: return $urandom_range(0, 127);
            default: return (len_model == 0) ? 0 : $urandom_range(1, len_model);
        endcase
    endfunction

    initial
    begin
        int n;
        int fsel;
        logic [31:0] w;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        send(FN_SEARCH, 1, 0);
        send(FN_READ, 1, 0);
        send(FN_SETLEN, 65, 0);
        send(FN_SETLEN, 127, 0);
        send(FN_SETLEN, 1, 0);
        send(FN_WRITE, 1, 32'h8000_0000);
        if (hw_model < 1) hw_model = 1;
        send(FN_INSERT, 1, 32'h7fff_ffff);
        send(FN_INSERT, 3, 32'h1);
        send(FN_READ, 2, 0);
        send(FN_READ, 0, 0);
        send(FN_SEARCH, 0, 32'h8000_0000);
        send(FN_SEARCH, 0, 32'h5);
        send(FN_WRITE, 3, 32'h5);
        send(FN_DELETE, 1, 0);
        send(FN_DELETE, 2, 0);
        send(FN_DELETE, 1, 0);
        send(FN_NOP6, 127, 32'hffff_ffff);
        send(FN_NOP7, 0, 0);
        // one written word so inserts can grow the list up to full
        send(FN_SETLEN, 1, 0);
        send(FN_WRITE, 1, $urandom());
        for (int i = 0; i < 64; i++) send(FN_INSERT, 1, $urandom());
        send(FN_INSERT, 1, 32'h3);
        send(FN_READ, 64, 0);
        send(FN_DELETE, 64, 0);

        // long receiver hold-off while items keep coming
        hold_off = 60;
        for (int i = 0; i < 20; i++) send(FN_SEARCH, 0, rand_word());

        n = 0;
        while (n < 1600)
        begin
            fsel = $urandom_range(0, 99);
            w = rand_word();
            if (fsel < 3)
            begin
                // set length only within cells already written
                send(FN_SETLEN, (fsel == 0) ? $urandom_range(65, 127)
                     : $urandom_range(0, hw_model), 0);
            end
            else if (fsel < 20) send(FN_WRITE, rand_pos(), w);
            else if (fsel < 38) send(FN_READ, rand_pos(), 0);
            else if (fsel < 62) send(FN_INSERT, rand_pos(), w);
            else if (fsel < 78) send(FN_DELETE, rand_pos(), 0);
            else if (fsel < 97)
            begin
                w = rand_word();
                send(FN_SEARCH, $urandom_range(0, 127), w);
            end
            else send(func_t'($urandom_range(6, 7)), $urandom_range(0, 127), $urandom());
            if (len_model == 0 && $urandom_range(0, 1)) send(FN_INSERT, 0, w);
            if (len_model == 0)
            begin
                send(FN_SETLEN, 1, 0);
                send(FN_WRITE, 1, w);
            end
            n++;
        end
        idle_out();

        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
